[src/flsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsd_pkg
// shared widths, codes, payload structs and the ordered dither table
// ----------------------------------------------------------------------------
package flsd_pkg;

   localparam int FRAC_BITS         = 16;
   localparam int TEX_SIZE_LOG2     = 6;
   localparam int COORD_W           = TEX_SIZE_LOG2 + FRAC_BITS;
   localparam int TEX_ADDR_W        = 2 * TEX_SIZE_LOG2;
   localparam int TEX_DEPTH         = 1 << TEX_ADDR_W;
   localparam int SHADE_W           = 5;
   localparam int X_W               = 9;
   localparam int ROW_W             = 8;
   localparam int BADDR_W           = 14;
   localparam int ROW_BYTES_DEFAULT = 52;

   localparam logic [SHADE_W-1:0] SHADE_MAX = 5'd16;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DRAW = 1'b1;

   typedef struct packed {
      logic                     action;
      logic [11:0]              texel_index;
      logic [7:0]               texel_value;
      logic [X_W-1:0]           span_start_x;
      logic [X_W-1:0]           span_end_x;
      logic [ROW_W-1:0]         span_row;
      logic [COORD_W-1:0]       u_start;
      logic [COORD_W-1:0]       v_start;
      logic [COORD_W-1:0]       u_step;
      logic [COORD_W-1:0]       v_step;
   } req_type;

   typedef struct packed {
      logic [BADDR_W-1:0] byte_address;
      logic [7:0]         write_data;
      logic [7:0]         write_mask;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [TEX_ADDR_W-1:0] addr;
      logic [SHADE_W-1:0]    data;
   } tex_wr_type;

   typedef struct packed {
      logic                  en;
      logic [TEX_ADDR_W-1:0] addr;
   } tex_rd_type;

   // 4-bit pattern of a shade level for one row phase, repeated across a byte
   function automatic logic [3:0] dither_nibble(input logic [SHADE_W-1:0] shade,
                                                input logic [1:0] phase);
      logic [15:0] w;
      case (shade)
         5'd0:    w = 16'h0000;
         5'd1:    w = 16'h8000;
         5'd2:    w = 16'h8020;
         5'd3:    w = 16'h80a0;
         5'd4:    w = 16'ha0a0;
         5'd5:    w = 16'ha0a1;
         5'd6:    w = 16'ha4a1;
         5'd7:    w = 16'ha4a5;
         5'd8:    w = 16'ha5a5;
         5'd9:    w = 16'hd5a5;
         5'd10:   w = 16'hd5e5;
         5'd11:   w = 16'hd5f5;
         5'd12:   w = 16'hf5f5;
         5'd13:   w = 16'hf5fd;
         5'd14:   w = 16'hf7fd;
         5'd15:   w = 16'hf7ff;
         default: w = 16'hffff;
      endcase
      case (phase)
         2'd0:    return w[15:12];
         2'd1:    return w[11:8];
         2'd2:    return w[7:4];
         default: return w[3:0];
      endcase
   endfunction

endpackage

[src/flsd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsd_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module flsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/flsd_span.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsd_span
// span walker: texel fetch per pixel, dither bit select and byte packing
// ----------------------------------------------------------------------------
module flsd_span #(
   parameter int ROW_BYTES = flsd_pkg::ROW_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  flsd_pkg::req_type                 req_item,
   output flsd_pkg::tex_wr_type              tex_wr,
   output flsd_pkg::tex_rd_type              tex_rd,
   input  logic [flsd_pkg::SHADE_W-1:0]      tex_rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output flsd_pkg::rsp_type                 rsp_item
);

   localparam int            X_W      = flsd_pkg::X_W;
   localparam int            COORD_W  = flsd_pkg::COORD_W;
   localparam int            TL       = flsd_pkg::TEX_SIZE_LOG2;
   localparam int            FB       = flsd_pkg::FRAC_BITS;
   localparam int            BADDR_W  = flsd_pkg::BADDR_W;
   localparam logic [11:0]   SCREEN_W = 12'(ROW_BYTES * 8);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMPTY} state_type;

   state_type               state_ff, state_in;
   logic [X_W-1:0]          x_ff, x_in;
   logic [X_W-1:0]          x2_ff, x2_in;
   logic [COORD_W-1:0]      u_ff, u_in, v_ff, v_in;
   logic [COORD_W-1:0]      du_ff, du_in, dv_ff, dv_in;
   logic [1:0]              phase_ff, phase_in;
   logic [BADDR_W-1:0]      row_base_ff, row_base_in;
   logic                    p1_valid_ff, p1_valid_in;
   logic [X_W-1:0]          p1_x_ff, p1_x_in;
   logic                    p1_last_ff, p1_last_in;
   logic [7:0]              acc_data_ff, acc_data_in, acc_mask_ff, acc_mask_in;
   logic                    out_valid_ff, out_valid_in;
   flsd_pkg::rsp_type       out_ff, out_in;

   logic                    req_fire;
   logic                    out_free;
   logic                    pix_emit;
   logic                    stall;
   logic                    advance;
   logic                    issue;
   logic [X_W-1:0]          x2_clip;
   logic [15:0]             row_prod;
   logic [3:0]              nib;
   logic [7:0]              bit_mask;
   logic [7:0]              pix_data;
   logic [7:0]              pix_mask;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign pix_emit  = p1_valid_ff && ((p1_x_ff[2:0] == 3'd7) || p1_last_ff);
   assign stall     = pix_emit && !out_free;
   assign advance   = !stall;
   assign issue     = (state_ff == ST_RUN) && (x_ff != x2_ff) && advance;

   assign x2_clip  = ({3'b000, req_item.span_end_x} > SCREEN_W) ? SCREEN_W[X_W-1:0]
                                                                : req_item.span_end_x;
   assign row_prod = {8'd0, req_item.span_row} * 16'(ROW_BYTES);

   assign tex_wr.en   = req_fire && (req_item.action == flsd_pkg::ACT_LOAD);
   assign tex_wr.addr = req_item.texel_index[flsd_pkg::TEX_ADDR_W-1:0];
   assign tex_wr.data = (req_item.texel_value > 8'(flsd_pkg::SHADE_MAX))
                        ? flsd_pkg::SHADE_MAX : req_item.texel_value[flsd_pkg::SHADE_W-1:0];

   assign tex_rd.en   = issue;
   assign tex_rd.addr = {v_ff[FB+TL-1:FB], u_ff[FB+TL-1:FB]};

   assign nib      = flsd_pkg::dither_nibble(tex_rd_data, phase_ff);
   assign bit_mask = 8'h80 >> p1_x_ff[2:0];
   assign pix_data = acc_data_ff | (nib[2'd3 - p1_x_ff[1:0]] ? bit_mask : 8'h00);
   assign pix_mask = acc_mask_ff | bit_mask;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      du_in        = du_ff;
      dv_in        = dv_ff;
      phase_in     = phase_ff;
      row_base_in  = row_base_ff;
      p1_valid_in  = p1_valid_ff;
      p1_x_in      = p1_x_ff;
      p1_last_in   = p1_last_ff;
      acc_data_in  = acc_data_ff;
      acc_mask_in  = acc_mask_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_item.action == flsd_pkg::ACT_DRAW)) begin
               x_in        = req_item.span_start_x;
               x2_in       = x2_clip;
               u_in        = req_item.u_start;
               v_in        = req_item.v_start;
               du_in       = req_item.u_step;
               dv_in       = req_item.v_step;
               phase_in    = req_item.span_row[1:0];
               row_base_in = row_prod[BADDR_W-1:0];
               acc_data_in = 8'h00;
               acc_mask_in = 8'h00;
               state_in    = (req_item.span_start_x >= x2_clip) ? ST_EMPTY : ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance) begin
               p1_valid_in = issue;
               if (issue) begin
                  p1_x_in    = x_ff;
                  p1_last_in = ((x_ff + 1'b1) == x2_ff);
                  x_in       = x_ff + 1'b1;
                  u_in       = u_ff + du_ff;
                  v_in       = v_ff + dv_ff;
               end
               if (p1_valid_ff) begin
                  if (pix_emit) begin
                     acc_data_in           = 8'h00;
                     acc_mask_in           = 8'h00;
                     out_valid_in          = 1'b1;
                     out_in.byte_address   = row_base_ff + BADDR_W'(p1_x_ff[X_W-1:3]);
                     out_in.write_data     = pix_data;
                     out_in.write_mask     = pix_mask;
                     out_in.last           = p1_last_ff;
                  end else begin
                     acc_data_in = pix_data;
                     acc_mask_in = pix_mask;
                  end
                  if (p1_last_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.byte_address = '0;
               out_in.write_data   = 8'h00;
               out_in.write_mask   = 8'h00;
               out_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      du_ff       <= du_in;
      dv_ff       <= dv_in;
      phase_ff    <= phase_in;
      row_base_ff <= row_base_in;
      p1_x_ff     <= p1_x_in;
      p1_last_ff  <= p1_last_in;
      acc_data_ff <= acc_data_in;
      acc_mask_ff <= acc_mask_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // pixel in flight only while a span is walked
   assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> state_ff == ST_RUN)
      else $error("pixel stage valid outside span walk");

   // texel read must not overwrite held data of a stalled pixel
   assert property (@(posedge clock) disable iff (reset)
      stall |-> !tex_rd.en)
      else $error("texture read issued during stall");

   // walker never passes the clipped end
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> x_ff <= x2_ff)
      else $error("span walker passed end column");

   // a pixel write always carries at least one mask bit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && pix_emit && advance) |=> rsp_valid && rsp_item.write_mask != 8'h00)
      else $error("pixel write with empty mask");

endmodule

[src/flat_span_dither_drawer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_span_dither_drawer_top
// affine texture-mapped span drawer with 4x4 ordered dither, 1-bit framebuffer
// ----------------------------------------------------------------------------
// A load transfer writes one texel and gives no result. A draw transfer walks
// its span at one pixel per cycle while byte writes do not wait on the result
// side, paced by the single read port of the texture ram; the input is held
// until the last pixel of the span has been packed. An empty span gives one
// masked-off write. The texture is not cleared after reset: every texel that
// a draw reads must have been loaded first.
// ----------------------------------------------------------------------------
module flat_span_dither_drawer_top #(
   parameter int ROW_BYTES = flsd_pkg::ROW_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // texel_index, texel_value, span_start_x, span_end_x, span_row,
   // u_start, v_start, u_step, v_step, zero fill
   input  logic [135:0]  req_tdata,
   // action
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // byte_address, write_data, write_mask, zero fill
   output logic [31:0]   rsp_tdata,
   output logic          rsp_tlast
);

   flsd_pkg::req_type                 req_item;
   flsd_pkg::rsp_type                 rsp_item;
   flsd_pkg::tex_wr_type              tex_wr;
   flsd_pkg::tex_rd_type              tex_rd;
   logic [flsd_pkg::SHADE_W-1:0]      tex_rd_data;

   assign req_item.action       = req_tuser[0];
   assign req_item.texel_index  = req_tdata[11:0];
   assign req_item.texel_value  = req_tdata[19:12];
   assign req_item.span_start_x = req_tdata[28:20];
   assign req_item.span_end_x   = req_tdata[37:29];
   assign req_item.span_row     = req_tdata[45:38];
   assign req_item.u_start      = req_tdata[67:46];
   assign req_item.v_start      = req_tdata[89:68];
   assign req_item.u_step       = req_tdata[111:90];
   assign req_item.v_step       = req_tdata[133:112];

   flsd_ram #(
      .WIDTH (flsd_pkg::SHADE_W),
      .DEPTH (flsd_pkg::TEX_DEPTH)
   ) u_tex_ram (
      .clock   (clock),
      .wr_en   (tex_wr.en),
      .wr_addr (tex_wr.addr),
      .wr_data (tex_wr.data),
      .rd_en   (tex_rd.en),
      .rd_addr (tex_rd.addr),
      .rd_data (tex_rd_data)
   );

   flsd_span #(
      .ROW_BYTES (ROW_BYTES)
   ) u_span (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .tex_wr      (tex_wr),
      .tex_rd      (tex_rd),
      .tex_rd_data (tex_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_item    (rsp_item)
   );

   assign rsp_tdata = {2'b00, rsp_item.write_mask, rsp_item.write_data,
                       rsp_item.byte_address};
   assign rsp_tlast = rsp_item.last;

endmodule
